// ----- sv/signed_binary_to_decimal_ascii_top_macros.svh -----
`ifndef SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH
`define SIGNED_BINARY_TO_DECIMAL_ASCII_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SBDA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SBDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/sbda_pkg.sv -----
`timescale 1ns / 1ps
package sbda_pkg;

  localparam int MAG_W      = 64;
  localparam int DIGITS     = 20;
  localparam int BCD_W      = 4 * DIGITS;
  localparam int BIT_CNT_W  = $clog2(MAG_W);
  localparam int DIG_CNT_W  = $clog2(DIGITS + 1);

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic bit_in;
    logic digit_shift;
  } dab_ctrl_t;

endpackage

// ----- sv/signed_binary_to_decimal_ascii_top.sv -----
// The first character follows the accepted word after the 64-step shift-and-add-3 loop
// and the skipping of any leading zero digits.
// A new number is taken only in idle, once the last digit of the previous one is issued.
// Characters leave one per cycle while out_stall is low.
// Reset (rst_n, synchronous, active low) returns the control to idle and drops out_valid.
`timescale 1ns / 1ps
`include "signed_binary_to_decimal_ascii_top_macros.svh"
module signed_binary_to_decimal_ascii_top
  import sbda_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic signed [63:0] in_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_character,
  output logic              out_last
);

  state_t               state_r, state_nxt;
  logic [MAG_W-1:0]     mag_r, mag_nxt;
  logic                 neg_r, neg_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 slot_free;
  dab_ctrl_t            ctrl;
  logic [3:0]           top_digit;

  sbda_dabble u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .top_digit (top_digit)
  );

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mag_r      <= mag_nxt;
    neg_r      <= neg_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    neg_nxt       = neg_r;
    bit_cnt_nxt   = bit_cnt_r;
    dig_cnt_nxt   = dig_cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    in_stall      = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          neg_nxt     = in_value[MAG_W-1];
          mag_nxt     = in_value[MAG_W-1] ? (~in_value + 64'd1) : in_value;
          bit_cnt_nxt = BIT_CNT_W'(MAG_W - 1);
          ctrl.clear  = 1'b1;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        ctrl.dabble = 1'b1;
        ctrl.bit_in = mag_r[MAG_W-1];
        mag_nxt     = {mag_r[MAG_W-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r - 1'b1;
        if (bit_cnt_r == '0) begin
          dig_cnt_nxt = DIG_CNT_W'(DIGITS);
          state_nxt   = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == 4'd0 && dig_cnt_r > DIG_CNT_W'(1)) begin
          ctrl.digit_shift = 1'b1;
          dig_cnt_nxt      = dig_cnt_r - 1'b1;
        end else if (neg_r) begin
          state_nxt = ST_SIGN;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_char_nxt     = ASCII_ZERO + {4'd0, top_digit};
          out_last_nxt     = (dig_cnt_r == DIG_CNT_W'(1));
          ctrl.digit_shift = 1'b1;
          dig_cnt_nxt      = dig_cnt_r - 1'b1;
          if (dig_cnt_r == DIG_CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  `SBDA_ASSERT_NEXT(a_conv_done, clk, rst_n, (state_r == ST_CONV && bit_cnt_r == '0), (state_r == ST_SKIP), "conversion did not end after the last bit")
  `SBDA_ASSERT_NOW(a_sign_not_last, clk, rst_n, (out_valid_r && out_char_r == ASCII_MINUS), (!out_last_r), "minus sign flagged as last character")
  `SBDA_ASSERT_NOW(a_emit_has_digit, clk, rst_n, (state_r == ST_EMIT || state_r == ST_SKIP), (dig_cnt_r != '0), "digit count ran out while emitting")

endmodule

// ----- sv/sbda_dabble.sv -----
`timescale 1ns / 1ps
module sbda_dabble
  import sbda_pkg::*;
(
  input  logic       clk,
  input  dab_ctrl_t  ctrl,
  output logic [3:0] top_digit
);

  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] bcd_nxt;
  logic [BCD_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_comb begin
    bcd_nxt = bcd_r;
    if (ctrl.clear) begin
      bcd_nxt = '0;
    end else if (ctrl.dabble) begin
      bcd_nxt = {adj[BCD_W-2:0], ctrl.bit_in};
    end else if (ctrl.digit_shift) begin
      bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bcd_r <= bcd_nxt;
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
  import sbda_pkg::*;

  localparam int          CYCLE_LIMIT   = 1_000_000;
  localparam int          HOLD_CYCLES   = 600;
  localparam int          DRAIN_CYCLES  = 100;
  localparam int          PHASE_ITEMS   = 116;
  localparam logic [63:0] DECIMAL_BASE  = 64'd10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  class decimal_text_scoreboard;
    text_char_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void note_number(logic signed [63:0] value);
      logic [63:0] magnitude;
      logic [7:0]  digit_codes[$];
      text_char_t  entry;
      magnitude = value[63] ? (~value + 64'd1) : value;
      do begin
        digit_codes.push_front(ASCII_ZERO + 8'(magnitude % DECIMAL_BASE));
        magnitude = magnitude / DECIMAL_BASE;
      end while (magnitude != 64'd0);
      if (value[63]) begin
        entry.code = ASCII_MINUS;
        entry.last = 1'b0;
        expected_chars.push_back(entry);
      end
      foreach (digit_codes[i]) begin
        entry.code = digit_codes[i];
        entry.last = (i == digit_codes.size() - 1);
        expected_chars.push_back(entry);
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        $error("Unexpected character %0d with last %0b.", code, last);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $error("character: expected %0d, got %0d", want.code, code);
        errors++;
      end
      if (last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_chars.size();
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [63:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_character;
  logic               out_last;

  int   send_idle_pct = 0;
  int   recv_idle_pct = 0;
  int   cycle_count = 0;
  logic hold_request = 1'b0;
  logic hold_off = 1'b0;

  decimal_text_scoreboard sb = new();

  signed_binary_to_decimal_ascii_top u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_character (out_character),
    .out_last      (out_last)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_number(in_value);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_char(out_character, out_last);
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_off || ($urandom_range(99) < recv_idle_pct);
  end

  // The receiver stops for a long stretch so the block backs up into its input.
  initial begin
    wait (hold_request === 1'b1);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_number(input logic signed [63:0] value);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  function automatic logic signed [63:0] pick_value();
    logic [63:0] magnitude;
    logic [63:0] power;
    int          ndigits;
    ndigits = $urandom_range(18, 1);
    power = 64'd1;
    repeat (ndigits) power = power * DECIMAL_BASE;
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: magnitude = {$urandom, $urandom} % power;
      2: magnitude = power + 64'($urandom_range(2)) - 64'd1;
      default: magnitude = 64'($urandom_range(999));
    endcase
    return $urandom_range(1) ? -magnitude : magnitude;
  endfunction

  task automatic run_random(input int count);
    repeat (count) send_number(pick_value());
  endtask

  initial begin
    logic signed [63:0] directed[$];
    directed = '{
      64'sd0, 64'sd1, -64'sd1, 64'sd9, -64'sd9, 64'sd10, -64'sd10, 64'sd99,
      64'sd100, -64'sd101,
      64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001, 64'h7FFF_FFFF_FFFF_FFFE,
      64'sd999999999999999999, 64'sd1000000000000000000,
      -64'sd1000000000000000000, -64'sd999999999999999999,
      64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'sd1234567890, -64'sd4294967296
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_number(directed[i]);

    send_idle_pct = 8;
    recv_idle_pct = 67;
    run_random(PHASE_ITEMS);

    send_idle_pct = 67;
    recv_idle_pct = 8;
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request <= 1'b1;
    run_random(PHASE_ITEMS);

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
